### rtl/bpp_pkg.sv
// Package for the byte pattern patcher.
// Holds the payload structs and the configuration register indexes.
// No dependencies.
`default_nettype none

package bpp_pkg;

  localparam int PAT_BYTES = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEARCH_PATTERN  = 3'd0,
    CFG_SEARCH_LEN      = 3'd1,
    CFG_REPLACE_PATTERN = 3'd2,
    CFG_REPLACE_LEN     = 3'd3,
    CFG_MAX_HITS        = 3'd4,
    CFG_WINDOW_START    = 3'd5,
    CFG_WINDOW_END      = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_last;
    logic [31:0] hit_count;
  } out_item_t;

endpackage

`default_nettype wire

### rtl/byte_pattern_patcher.sv
// Byte pattern patcher top level: streaming search and replace over an image.
// Uses bpp_pkg for payload structs and register indexes.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_item  (bpp_pkg::in_item_t)
//   out      output     out_valid/ out_stall out_item (bpp_pkg::out_item_t)
//   cfg      input      cfg_valid/ cfg_ready cfg_index, cfg_data
//
// One byte per cycle in steady state: the window fills to MAX_PATTERN bytes,
// then each cycle compares the head, patches, emits it and takes a new byte.
// A byte with in_last starts a drain of the window, one byte a cycle while
// out_stall allows; in_stall stays high for the drain. Synchronous reset clears
// stream state and configuration registers, but sets window_end to all ones.
// out_stall holds the output register; a full window then stalls the input.
`default_nettype none

module byte_pattern_patcher #(
  parameter int MAX_PATTERN = 8,
  parameter int ADDR_BITS   = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire bpp_pkg::in_item_t               in_item,
  output      logic                            out_valid,
  input  wire logic                            out_stall,
  output      bpp_pkg::out_item_t              out_item,
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [bpp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bpp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int PAT_LIMIT = (MAX_PATTERN < bpp_pkg::PAT_BYTES) ? MAX_PATTERN
                                                                : bpp_pkg::PAT_BYTES;
  localparam int FW    = $clog2(MAX_PATTERN + 1);
  localparam int LW    = (FW > 4) ? FW : 4;
  localparam int CMP_W = ((ADDR_BITS > 32) ? ADDR_BITS : 32) + 1;

  // configuration registers
  logic [63:0] search_pattern;
  logic [3:0]  search_len;
  logic [63:0] replace_pattern;
  logic [3:0]  replace_len;
  logic [31:0] max_hits;
  logic [31:0] window_start;
  logic [31:0] window_end;

  // stream state
  logic [7:0]           win      [MAX_PATTERN];
  logic [7:0]           win_next [MAX_PATTERN];
  logic [7:0]           pw       [MAX_PATTERN];
  logic [FW-1:0]        fill, fill_next, fill_after;
  logic [ADDR_BITS-1:0] addr, addr_next;
  logic [31:0]          hits, hits_next, hits_inc;
  logic [3:0]           skip, skip_next;
  logic                 drain, drain_next;

  logic       out_free, emit_go, accept, len_ok, cap_hit, in_range, bytes_eq;
  logic       match, last_out;
  logic [3:0] lim;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign emit_go   = (fill == FW'(MAX_PATTERN) || (drain && fill != '0)) && out_free;
  assign in_stall  = drain || (fill == FW'(MAX_PATTERN) && !out_free);
  assign accept    = in_valid && !in_stall;
  assign last_out  = drain && fill == FW'(1);

  always_comb begin
    len_ok = search_len != 4'd0 && replace_len != 4'd0 &&
             search_len <= 4'(PAT_LIMIT) && replace_len <= 4'(PAT_LIMIT);
    cap_hit = max_hits != 32'd0 && hits >= max_hits;
    lim = (search_len > replace_len) ? search_len : replace_len;
    // the image length clip reduces to the window fill check
    in_range = CMP_W'(addr) >= CMP_W'(window_start) &&
               CMP_W'(addr) + CMP_W'(lim) <= CMP_W'(window_end) &&
               LW'(lim) <= LW'(fill);
    bytes_eq = 1'b1;
    for (int i = 0; i < PAT_LIMIT; i++) begin
      if (4'(i) < search_len && win[i] != search_pattern[8*i +: 8]) begin
        bytes_eq = 1'b0;
      end
    end
    match = emit_go && skip == 4'd0 && len_ok && !cap_hit && in_range && bytes_eq;
    hits_inc = hits + 32'(match);

    for (int i = 0; i < MAX_PATTERN; i++) begin
      pw[i] = win[i];
    end
    for (int i = 0; i < PAT_LIMIT; i++) begin
      if (match && 4'(i) < replace_len) begin
        pw[i] = replace_pattern[8*i +: 8];
      end
    end
  end

  always_comb begin
    fill_after = fill - FW'(emit_go);
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (emit_go && i < MAX_PATTERN - 1) begin
        win_next[i] = pw[(i < MAX_PATTERN - 1) ? i + 1 : i];
      end else begin
        win_next[i] = win[i];
      end
      if (accept && fill_after == FW'(i)) begin
        win_next[i] = in_item.data_byte;
      end
    end
    fill_next  = fill_after + FW'(accept);
    addr_next  = addr + ADDR_BITS'(emit_go);
    hits_next  = hits_inc;
    skip_next  = skip;
    drain_next = drain || (accept && in_item.in_last);
    if (emit_go) begin
      if (skip != 4'd0) begin
        skip_next = skip - 4'd1;
      end else if (match) begin
        skip_next = search_len - 4'd1;
      end
    end
    if (emit_go && last_out) begin
      fill_next  = '0;
      addr_next  = '0;
      hits_next  = '0;
      skip_next  = '0;
      drain_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      win[i] <= win_next[i];
    end
    if (emit_go) begin
      out_item.out_byte  <= pw[0];
      out_item.out_last  <= last_out;
      out_item.hit_count <= hits_inc;
    end
    if (rst) begin
      fill      <= '0;
      addr      <= '0;
      hits      <= '0;
      skip      <= '0;
      drain     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      fill  <= fill_next;
      addr  <= addr_next;
      hits  <= hits_next;
      skip  <= skip_next;
      drain <= drain_next;
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      search_pattern  <= '0;
      search_len      <= '0;
      replace_pattern <= '0;
      replace_len     <= '0;
      max_hits        <= '0;
      window_start    <= '0;
      window_end      <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bpp_pkg::CFG_SEARCH_PATTERN:  search_pattern  <= cfg_data;
        bpp_pkg::CFG_SEARCH_LEN:      search_len      <= cfg_data[3:0];
        bpp_pkg::CFG_REPLACE_PATTERN: replace_pattern <= cfg_data;
        bpp_pkg::CFG_REPLACE_LEN:     replace_len     <= cfg_data[3:0];
        bpp_pkg::CFG_MAX_HITS:        max_hits        <= cfg_data[31:0];
        bpp_pkg::CFG_WINDOW_START:    window_start    <= cfg_data[31:0];
        bpp_pkg::CFG_WINDOW_END:      window_end      <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(MAX_PATTERN))
    else $error("window fill above depth");

  a_skip_bound: assert property (@(posedge clk) disable iff (rst)
    skip < 4'(PAT_LIMIT))
    else $error("skip count above pattern limit");

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    accept && in_item.in_last |=> drain)
    else $error("last transfer did not start drain");

endmodule

`default_nettype wire
